@@ rtl/stmd_pkg.sv @@
// shared types, codes and helpers of the stop mark detect sequencer
`default_nettype none
package stmd_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SENSOR_W = 5;
  localparam int unsigned CODE_W   = 2;
  localparam int unsigned SCORE_W  = 3;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned STABLE_W = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_NEEDED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MS         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_MS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_BLANK_MS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_STOPS     = 3'd6;

  // register reset values
  localparam logic [STABLE_W-1:0] RST_STABLE_NEEDED   = 4'd1;
  localparam logic [MS_W-1:0]     RST_WAIT_MS         = 16'd3000;
  localparam logic [MS_W-1:0]     RST_BYPASS_MS       = 16'd800;
  localparam logic [MS_W-1:0]     RST_IGNORE_MS       = 16'd1000;
  localparam logic [MS_W-1:0]     RST_MIN_INTERVAL_MS = 16'd1000;
  localparam logic [MS_W-1:0]     RST_BOOT_BLANK_MS   = 16'd3000;
  localparam logic [IDX_W-1:0]    RST_TOTAL_STOPS     = 8'd4;

  // drive command codes
  localparam logic [CODE_W-1:0] CMD_NORMAL   = 2'd0;
  localparam logic [CODE_W-1:0] CMD_BRAKE    = 2'd1;
  localparam logic [CODE_W-1:0] CMD_APPROACH = 2'd2;
  localparam logic [CODE_W-1:0] CMD_STRAIGHT = 2'd3;

  // reported mode codes
  localparam logic [CODE_W-1:0] MODE_CODE_FOLLOW = 2'd0;
  localparam logic [CODE_W-1:0] MODE_CODE_DWELL  = 2'd1;
  localparam logic [CODE_W-1:0] MODE_CODE_BYPASS = 2'd2;

  // event codes
  localparam logic [CODE_W-1:0] EV_NONE       = 2'd0;
  localparam logic [CODE_W-1:0] EV_DETECT     = 2'd1;
  localparam logic [CODE_W-1:0] EV_DWELL_DONE = 2'd2;

  // sensor patterns and scores
  localparam logic [SENSOR_W-1:0] PAT_ALL         = 5'b11111;
  localparam logic [SENSOR_W-1:0] PAT_MID3        = 5'b01110;
  localparam logic [SENSOR_W-1:0] BIT_LEFT_OUTER  = 5'b00001;
  localparam logic [SENSOR_W-1:0] BIT_RIGHT_OUTER = 5'b10000;
  localparam logic [SCORE_W-1:0]  SCORE_NONE = 3'd0;
  localparam logic [SCORE_W-1:0]  SCORE_MID  = 3'd3;
  localparam logic [SCORE_W-1:0]  SCORE_FULL = 3'd5;

  localparam logic [IDX_W-1:0]   STOP_FIRST = 8'd1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_FOLLOW = 3'b001,
    MODE_DWELL  = 3'b010,
    MODE_BYPASS = 3'b100
  } mode_t;

  typedef struct packed {
    logic [TIME_W-1:0]   now_ms;
    logic [SENSOR_W-1:0] sensor_bits;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  drive_cmd;
    logic [CODE_W-1:0]  mode_now;
    logic [CODE_W-1:0]  event_code;
    logic [IDX_W-1:0]   stop_index;
    logic [TOTAL_W-1:0] stops_seen;
    logic [SCORE_W-1:0] cross_score;
  } out_item_t;

  typedef struct packed {
    logic [STABLE_W-1:0] stable_needed;
    logic [MS_W-1:0]     wait_ms;
    logic [MS_W-1:0]     bypass_ms;
    logic [MS_W-1:0]     ignore_ms;
    logic [MS_W-1:0]     min_interval_ms;
    logic [MS_W-1:0]     boot_blank_ms;
    logic [IDX_W-1:0]    total_stops;
  } cfg_t;

  typedef struct packed {
    mode_t               mode;
    logic [CNT_W-1:0]    cross_counter;
    logic [IDX_W-1:0]    stop_number;
    logic [TOTAL_W-1:0]  stop_total;
    logic [TIME_W-1:0]   ignore_until;
    logic [TIME_W-1:0]   wait_until;
    logic [TIME_W-1:0]   bypass_until;
    logic [TIME_W-1:0]   last_detect_time;
    logic                started;
  } state_t;

  function automatic logic [SCORE_W-1:0] mark_score(input logic [SENSOR_W-1:0] bits);
    logic [SCORE_W-1:0] s;
    s = SCORE_NONE;
    if (((bits & BIT_LEFT_OUTER) != '0) && ((bits & BIT_RIGHT_OUTER) != '0)) begin
      s = SCORE_FULL;
    end else if (bits == PAT_ALL) begin
      s = SCORE_FULL;
    end else if (bits == PAT_MID3) begin
      s = SCORE_MID;
    end
    return s;
  endfunction

  function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
    logic [CODE_W-1:0] c;
    unique case (m)
      MODE_DWELL:  c = MODE_CODE_DWELL;
      MODE_BYPASS: c = MODE_CODE_BYPASS;
      default:     c = MODE_CODE_FOLLOW;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/stmd_step.sv @@
// next state and result for one sample
`default_nettype none
module stmd_step (
  input  stmd_pkg::cfg_t      cfg,
  input  stmd_pkg::state_t    st,
  input  stmd_pkg::in_item_t  item,
  output stmd_pkg::state_t    st_nxt,
  output stmd_pkg::out_item_t res
);
  import stmd_pkg::*;

  logic [SCORE_W-1:0] score;
  logic [TIME_W-1:0]  ign;
  logic [TIME_W-1:0]  since;
  logic               blanked;
  logic [CNT_W-1:0]   cap;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W:0]     num_inc;
  logic [CODE_W-1:0]  drive;
  logic [CODE_W-1:0]  ev;

  assign score = mark_score(item.sensor_bits);
  assign ign   = st.started ? st.ignore_until
                            : item.now_ms + {{(TIME_W-MS_W){1'b0}}, cfg.boot_blank_ms};
  assign since = item.now_ms - st.last_detect_time;
  assign blanked = (item.now_ms < ign) ||
                   (since < {{(TIME_W-MS_W){1'b0}}, cfg.min_interval_ms});
  assign cap     = {1'b0, cfg.stable_needed} + CNT_W'(2);
  assign num_inc = {1'b0, st.stop_number} + (IDX_W+1)'(1);

  always_comb begin
    if (score >= SCORE_FULL) begin
      cnt = st.cross_counter + CNT_W'(2);
    end else if (score >= SCORE_MID) begin
      cnt = st.cross_counter + CNT_W'(1);
    end else if (st.cross_counter != '0) begin
      cnt = st.cross_counter - CNT_W'(1);
    end else begin
      cnt = '0;
    end
    if (cnt > cap) begin
      cnt = cap;
    end
  end

  always_comb begin
    st_nxt = st;
    st_nxt.started = 1'b1;
    st_nxt.ignore_until = ign;
    drive = CMD_NORMAL;
    ev = EV_NONE;
    unique case (st.mode)
      MODE_DWELL: begin
        drive = CMD_BRAKE;
        if (item.now_ms >= st.wait_until) begin
          st_nxt.mode = MODE_BYPASS;
          st_nxt.bypass_until = item.now_ms + {{(TIME_W-MS_W){1'b0}}, cfg.bypass_ms};
          st_nxt.ignore_until = item.now_ms + {{(TIME_W-MS_W){1'b0}}, cfg.ignore_ms};
          ev = EV_DWELL_DONE;
        end
      end
      MODE_BYPASS: begin
        drive = CMD_STRAIGHT;
        if (item.now_ms >= st.bypass_until) begin
          st_nxt.mode = MODE_FOLLOW;
        end
      end
      default: begin
        st_nxt.mode = MODE_FOLLOW;
        if (blanked) begin
          st_nxt.cross_counter = '0;
        end else begin
          st_nxt.cross_counter = cnt;
          if (score >= SCORE_MID) begin
            drive = CMD_APPROACH;
          end
          if (cnt >= {1'b0, cfg.stable_needed}) begin
            st_nxt.cross_counter = '0;
            if (st.stop_total != TOTAL_MAX) begin
              st_nxt.stop_total = st.stop_total + TOTAL_W'(1);
            end
            if (num_inc > {1'b0, cfg.total_stops}) begin
              st_nxt.stop_number = STOP_FIRST;
            end else begin
              st_nxt.stop_number = num_inc[IDX_W-1:0];
            end
            st_nxt.last_detect_time = item.now_ms;
            st_nxt.wait_until = item.now_ms + {{(TIME_W-MS_W){1'b0}}, cfg.wait_ms};
            st_nxt.mode = MODE_DWELL;
            drive = CMD_BRAKE;
            ev = EV_DETECT;
          end
        end
      end
    endcase
  end

  always_comb begin
    res.drive_cmd   = drive;
    res.mode_now    = mode_code(st_nxt.mode);
    res.event_code  = ev;
    res.stop_index  = st_nxt.stop_number;
    res.stops_seen  = st_nxt.stop_total;
    res.cross_score = score;
  end

endmodule
`default_nettype wire

@@ rtl/stmd_cfg_regs.sv @@
// configuration register file
`default_nettype none
module stmd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [stmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stmd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output stmd_pkg::cfg_t                     cfg
);
  import stmd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_STABLE_NEEDED:   cfg_nxt.stable_needed   = cfg_wdata[STABLE_W-1:0];
        CFG_WAIT_MS:         cfg_nxt.wait_ms         = cfg_wdata[MS_W-1:0];
        CFG_BYPASS_MS:       cfg_nxt.bypass_ms       = cfg_wdata[MS_W-1:0];
        CFG_IGNORE_MS:       cfg_nxt.ignore_ms       = cfg_wdata[MS_W-1:0];
        CFG_MIN_INTERVAL_MS: cfg_nxt.min_interval_ms = cfg_wdata[MS_W-1:0];
        CFG_BOOT_BLANK_MS:   cfg_nxt.boot_blank_ms   = cfg_wdata[MS_W-1:0];
        CFG_TOTAL_STOPS:     cfg_nxt.total_stops     = cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stable_needed   <= RST_STABLE_NEEDED;
      cfg_r.wait_ms         <= RST_WAIT_MS;
      cfg_r.bypass_ms       <= RST_BYPASS_MS;
      cfg_r.ignore_ms       <= RST_IGNORE_MS;
      cfg_r.min_interval_ms <= RST_MIN_INTERVAL_MS;
      cfg_r.boot_blank_ms   <= RST_BOOT_BLANK_MS;
      cfg_r.total_stops     <= RST_TOTAL_STOPS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ rtl/stop_mark_detect_sequencer_core.sv @@
// an accepted item is held in the input register, and its result in the result register
// throughput: one item per cycle unless out_ready low holds the result register; the input
// register feeds the result register through a single pass of scoring, counter and deadline compares
// in_ready drops only while the result register is held by out_ready low
// reset (synchronous, rst_n low): registers to defaults, mode following,
// all counters and deadlines zero, both stages empty
`default_nettype none
module stop_mark_detect_sequencer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  stmd_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output stmd_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [stmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import stmd_pkg::*;

  cfg_t      cfg;
  state_t    st_r;
  state_t    st_nxt;
  in_item_t  in_item_r;
  logic      in_valid_r;
  logic      in_valid_nxt;
  out_item_t out_item_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t res;
  logic      advance;

  stmd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  stmd_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (in_item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.mode             <= MODE_FOLLOW;
      st_r.cross_counter    <= '0;
      st_r.stop_number      <= '0;
      st_r.stop_total       <= '0;
      st_r.ignore_until     <= '0;
      st_r.wait_until       <= '0;
      st_r.bypass_until     <= '0;
      st_r.last_detect_time <= '0;
      st_r.started          <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

@@ rtl/stmd_checker.sv @@
// port level checks of the stop mark detect sequencer
`default_nettype none
module stmd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input stmd_pkg::out_item_t out_item
);
  import stmd_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // detection brakes and enters dwell
  a_detect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.event_code == EV_DETECT |->
      out_item.drive_cmd == CMD_BRAKE && out_item.mode_now == MODE_CODE_DWELL &&
      out_item.stop_index != '0 && out_item.stops_seen != '0)
    else $error("bad detect item");

  // dwell end still brakes and moves to bypass
  a_dwell_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.event_code == EV_DWELL_DONE |->
      out_item.drive_cmd == CMD_BRAKE && out_item.mode_now == MODE_CODE_BYPASS)
    else $error("bad dwell finished item");

  // dwelling always brakes
  a_dwell_brake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.mode_now == MODE_CODE_DWELL |->
      out_item.drive_cmd == CMD_BRAKE)
    else $error("dwell without brake");

  a_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.cross_score == SCORE_NONE ||
      out_item.cross_score == SCORE_MID || out_item.cross_score == SCORE_FULL)
    else $error("bad crossing score");

endmodule

bind stop_mark_detect_sequencer_core stmd_checker u_stmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench of the stop mark detect sequencer: directed and random samples checked item by item
module tb_top;
  import stmd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  stop_mark_detect_sequencer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies
  logic [STABLE_W-1:0] st_need = RST_STABLE_NEEDED;
  logic [MS_W-1:0] st_wait_ms = RST_WAIT_MS;
  logic [MS_W-1:0] st_bypass_ms = RST_BYPASS_MS;
  logic [MS_W-1:0] st_ignore_ms = RST_IGNORE_MS;
  logic [MS_W-1:0] st_interval_ms = RST_MIN_INTERVAL_MS;
  logic [MS_W-1:0] st_start_ms = RST_BOOT_BLANK_MS;
  logic [IDX_W-1:0] st_total = RST_TOTAL_STOPS;

  // sequencer state
  mode_t st_mode = MODE_FOLLOW;
  logic [CNT_W-1:0] st_count = '0;
  logic [IDX_W-1:0] st_stop_no = '0;
  logic [TOTAL_W-1:0] st_stops = '0;
  logic [TIME_W-1:0] st_ignore_until = '0;
  logic [TIME_W-1:0] st_wait_until = '0;
  logic [TIME_W-1:0] st_bypass_until = '0;
  logic [TIME_W-1:0] st_last_detect = '0;
  logic st_started = 1'b0;

  out_item_t drive_results_due[$];
  out_item_t want_item;
  int mismatch_count = 0;
  int results_seen = 0;
  int idle_pct = 25;
  int hold_left = 0;
  int unsigned cycle_count = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  function automatic out_item_t predict_drive_result(input in_item_t it);
    logic [SCORE_W-1:0] score;
    logic [CODE_W-1:0] drive;
    logic [CODE_W-1:0] ev;
    logic [TIME_W-1:0] since;
    logic [CNT_W-1:0] cap;
    logic blanked;
    out_item_t r;
    if (it.sensor_bits[0] && it.sensor_bits[4]) begin
      score = SCORE_FULL;
    end else if (it.sensor_bits == PAT_MID3) begin
      score = SCORE_MID;
    end else begin
      score = SCORE_NONE;
    end
    drive = CMD_NORMAL;
    ev = EV_NONE;
    if (!st_started) begin
      st_ignore_until = it.now_ms + st_start_ms;
      st_started = 1'b1;
    end
    case (st_mode)
      MODE_DWELL: begin
        drive = CMD_BRAKE;
        if (it.now_ms >= st_wait_until) begin
          st_mode = MODE_BYPASS;
          st_bypass_until = it.now_ms + st_bypass_ms;
          st_ignore_until = it.now_ms + st_ignore_ms;
          ev = EV_DWELL_DONE;
        end
      end
      MODE_BYPASS: begin
        drive = CMD_STRAIGHT;
        if (it.now_ms >= st_bypass_until) st_mode = MODE_FOLLOW;
      end
      default: begin
        since = it.now_ms - st_last_detect;
        blanked = (it.now_ms < st_ignore_until) || (since < {16'd0, st_interval_ms});
        st_mode = MODE_FOLLOW;
        if (blanked) begin
          st_count = '0;
        end else begin
          cap = {1'b0, st_need} + 5'd2;
          if (score == SCORE_FULL) begin
            st_count = st_count + 5'd2;
          end else if (score == SCORE_MID) begin
            st_count = st_count + 5'd1;
          end else if (st_count != '0) begin
            st_count = st_count - 5'd1;
          end
          if (st_count > cap) st_count = cap;
          if (score != SCORE_NONE) drive = CMD_APPROACH;
          if (st_count >= {1'b0, st_need}) begin
            st_count = '0;
            if (st_stops != TOTAL_MAX) st_stops = st_stops + 1'b1;
            if ({1'b0, st_stop_no} + 9'd1 > {1'b0, st_total}) begin
              st_stop_no = STOP_FIRST;
            end else begin
              st_stop_no = st_stop_no + 1'b1;
            end
            st_last_detect = it.now_ms;
            st_wait_until = it.now_ms + st_wait_ms;
            st_mode = MODE_DWELL;
            drive = CMD_BRAKE;
            ev = EV_DETECT;
          end
        end
      end
    endcase
    r.drive_cmd = drive;
    case (st_mode)
      MODE_DWELL: r.mode_now = MODE_CODE_DWELL;
      MODE_BYPASS: r.mode_now = MODE_CODE_BYPASS;
      default: r.mode_now = MODE_CODE_FOLLOW;
    endcase
    r.event_code = ev;
    r.stop_index = st_stop_no;
    r.stops_seen = st_stops;
    r.cross_score = score;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("mismatch at result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready = ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (drive_results_due.size() == 0) begin
        report_mismatch("item with no result due");
      end else begin
        want_item = drive_results_due.pop_front();
        if (out_item.drive_cmd !== want_item.drive_cmd)
          report_mismatch($sformatf("drive_cmd %0d, due %0d",
                                    out_item.drive_cmd, want_item.drive_cmd));
        if (out_item.mode_now !== want_item.mode_now)
          report_mismatch($sformatf("mode_now %0d, due %0d",
                                    out_item.mode_now, want_item.mode_now));
        if (out_item.event_code !== want_item.event_code)
          report_mismatch($sformatf("event_code %0d, due %0d",
                                    out_item.event_code, want_item.event_code));
        if (out_item.stop_index !== want_item.stop_index)
          report_mismatch($sformatf("stop_index %0d, due %0d",
                                    out_item.stop_index, want_item.stop_index));
        if (out_item.stops_seen !== want_item.stops_seen)
          report_mismatch($sformatf("stops_seen %0d, due %0d",
                                    out_item.stops_seen, want_item.stops_seen));
        if (out_item.cross_score !== want_item.cross_score)
          report_mismatch($sformatf("cross_score %0d, due %0d",
                                    out_item.cross_score, want_item.cross_score));
      end
      results_seen++;
    end
  end

  task automatic send_sample(input logic [TIME_W-1:0] t, input logic [SENSOR_W-1:0] bits);
    in_item_t item;
    item.now_ms = t;
    item.sensor_bits = bits;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_item = item;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    drive_results_due.push_back(predict_drive_result(item));
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (drive_results_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_STABLE_NEEDED: st_need = data[STABLE_W-1:0];
      CFG_WAIT_MS: st_wait_ms = data;
      CFG_BYPASS_MS: st_bypass_ms = data;
      CFG_IGNORE_MS: st_ignore_ms = data;
      CFG_MIN_INTERVAL_MS: st_interval_ms = data;
      CFG_BOOT_BLANK_MS: st_start_ms = data;
      CFG_TOTAL_STOPS: st_total = data[IDX_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [TIME_W-1:0] next_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      clock_ms = clock_ms + $urandom_range(0, 80);
    end else if (r < 90) begin
      clock_ms = clock_ms + $urandom_range(0, 70000);
    end else if (r < 94) begin
      clock_ms = clock_ms - $urandom_range(1, 500);
    end else if (r < 97) begin
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
    end else begin
      clock_ms = $urandom();
    end
    return clock_ms;
  endfunction

  function automatic logic [MS_W-1:0] random_ms();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return '0;
    if (r == 2) return 16'hFFFF;
    return MS_W'($urandom_range(0, 400));
  endfunction

  // start-up blanking, a first stop, dwell, bypass and a second stop at reset settings
  task automatic test_reset_values_and_first_sample();
    send_sample(32'd100, PAT_ALL);
    send_sample(32'd200, 5'b00000);
    send_sample(32'd3100, PAT_MID3);
    send_sample(32'd3200, 5'b10001);
    send_sample(32'd6100, 5'b00100);
    send_sample(32'd6500, BIT_RIGHT_OUTER);
    send_sample(32'd6900, BIT_LEFT_OUTER);
    send_sample(32'd7000, PAT_MID3);
    send_sample(32'd7100, 5'b11011);
    clock_ms = 32'd7100;
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(CFG_STABLE_NEEDED, 16'd15);
    write_reg(CFG_WAIT_MS, 16'hFFFF);
    write_reg(CFG_BYPASS_MS, 16'hFFFF);
    write_reg(CFG_IGNORE_MS, 16'hFFFF);
    write_reg(CFG_MIN_INTERVAL_MS, 16'hFFFF);
    write_reg(CFG_BOOT_BLANK_MS, 16'hFFFF);
    write_reg(CFG_TOTAL_STOPS, 16'h00FF);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_sample(32'd10100, 5'b00000);
    send_sample(32'd75635, PAT_ALL);
    clock_ms = 32'd141170;
    send_sample(clock_ms, PAT_MID3);
    send_sample(clock_ms, PAT_MID3);
    repeat (7) begin
      clock_ms = clock_ms + 1;
      send_sample(clock_ms, PAT_ALL);
    end
    settle();
    // upper data bits beyond a narrow register are dropped
    write_reg(CFG_STABLE_NEEDED, 16'hFFF0);
    write_reg(CFG_TOTAL_STOPS, 16'hFF00);
    write_reg(CFG_WAIT_MS, 16'd0);
    write_reg(CFG_BYPASS_MS, 16'd0);
    write_reg(CFG_IGNORE_MS, 16'd0);
    write_reg(CFG_MIN_INTERVAL_MS, 16'd0);
    clock_ms = clock_ms + 32'd65535;
    send_sample(clock_ms, 5'b10101);
    send_sample(clock_ms, 5'b01010);
    repeat (3) send_sample(clock_ms, SENSOR_W'($urandom_range(0, 31)));
    // timestamps running backwards across the wrap
    send_sample(32'hFFFF_FFF0, 5'b11111);
    send_sample(32'd5, 5'b00000);
    send_sample(32'd4, PAT_MID3);
    clock_ms = 32'd4;
  endtask

  task automatic test_random_phases();
    int burst;
    logic [2:0] mid;
    logic [SENSOR_W-1:0] bits;
    burst = 0;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      idle_pct = (ph == 2) ? 0 : 25;
      case ($urandom_range(0, 9))
        0: write_reg(CFG_STABLE_NEEDED, 16'd0);
        1: write_reg(CFG_STABLE_NEEDED, 16'd15);
        default: write_reg(CFG_STABLE_NEEDED, CFG_DATA_W'($urandom_range(1, 4)));
      endcase
      write_reg(CFG_WAIT_MS, random_ms());
      write_reg(CFG_BYPASS_MS, random_ms());
      write_reg(CFG_IGNORE_MS, random_ms());
      write_reg(CFG_MIN_INTERVAL_MS, random_ms());
      write_reg(CFG_BOOT_BLANK_MS, random_ms());
      case ($urandom_range(0, 9))
        0: write_reg(CFG_TOTAL_STOPS, 16'd0);
        1: write_reg(CFG_TOTAL_STOPS, 16'd255);
        default: write_reg(CFG_TOTAL_STOPS, CFG_DATA_W'($urandom_range(1, 6)));
      endcase
      for (int n = 0; n < 100; n++) begin
        if (burst == 0 && $urandom_range(0, 99) < 40) burst = $urandom_range(1, st_need + 3);
        if (burst > 0) begin
          burst--;
          mid = 3'($urandom_range(0, 7));
          case ($urandom_range(0, 2))
            0: bits = PAT_MID3;
            1: bits = PAT_ALL;
            default: bits = {1'b1, mid, 1'b1};
          endcase
        end else begin
          bits = SENSOR_W'($urandom_range(0, 31));
        end
        send_sample(next_time(), bits);
      end
    end
  endtask

  // receiver holds off while samples keep coming, so the input stalls
  task automatic test_output_backpressure();
    settle();
    idle_pct = 25;
    hold_left = 200;
    repeat (40) send_sample(next_time(), SENSOR_W'($urandom_range(0, 31)));
  endtask

  // a stop on every third sample, with the index wrapping back to one several times
  task automatic test_index_wrap();
    settle();
    idle_pct = 10;
    write_reg(CFG_STABLE_NEEDED, 16'd0);
    write_reg(CFG_WAIT_MS, 16'd0);
    write_reg(CFG_BYPASS_MS, 16'd0);
    write_reg(CFG_IGNORE_MS, 16'd0);
    write_reg(CFG_MIN_INTERVAL_MS, 16'd0);
    write_reg(CFG_BOOT_BLANK_MS, 16'd0);
    write_reg(CFG_TOTAL_STOPS, 16'd3);
    if (st_ignore_until > clock_ms) clock_ms = st_ignore_until;
    if (st_wait_until > clock_ms) clock_ms = st_wait_until;
    if (st_bypass_until > clock_ms) clock_ms = st_bypass_until;
    repeat (40) begin
      if (clock_ms < 32'hFFFF_0000) clock_ms = clock_ms + $urandom_range(0, 1);
      send_sample(clock_ms, SENSOR_W'($urandom_range(0, 31)));
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_reset_values_and_first_sample();
    test_register_extremes();
    test_random_phases();
    test_output_backpressure();
    test_index_wrap();
    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && drive_results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
